// ----- hdl/asa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the aligned stack allocator.
// No dependencies; used by asa_ctrl, asa_dp and aligned_stack_allocator.
package asa_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned STACK_DEPTH  = 64;
    localparam int unsigned SLOT_W       = $clog2(STACK_DEPTH);
    localparam int unsigned COUNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADJ_W        = 8;
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned ALIGN_W      = 8;

    // Register indexes on the configuration port
    localparam logic REG_REGION_BASE  = 1'b0;
    localparam logic REG_REGION_BYTES = 1'b1;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_ARG = 3'd1,
        ST_NO_MEM  = 3'd2,
        ST_NOT_TOP = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic exec;
    } cmd_t;

    // Configuration write strobes
    typedef struct packed {
        logic                base_we;
        logic                bytes_we;
        logic [ADDR_W-1:0]   data;
    } cfg_wr_t;

    // Configuration read-back
    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_bytes;
    } cfg_rd_t;

    // One stack entry
    typedef struct packed {
        logic [ADJ_W-1:0]  adj;
        logic [ADDR_W-1:0] block;
    } entry_t;

endpackage

// ----- hdl/asa_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine of the aligned stack allocator.
// Depends on asa_pkg; drives the asa_dp commands and both handshakes.
module asa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output asa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        IDLE_S,
        LOOKUP_S,
        EXEC_S,
        RESP_S
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    // Commands follow the state
    assign s_tready   = (state_reg == IDLE_S);
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.lookup = (state_reg == LOOKUP_S);
    assign cmd.exec   = (state_reg == EXEC_S);
    assign m_tvalid   = m_tvalid_reg;

    // Next state and result valid
    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        case (state_reg)
            IDLE_S:
            begin
                if (s_tvalid)
                begin
                    state_next = LOOKUP_S;
                end
            end
            LOOKUP_S:
            begin
                state_next = EXEC_S;
            end
            EXEC_S:
            begin
                state_next    = RESP_S;
                m_tvalid_next = 1'b1;
            end
            RESP_S:
            begin
                if (m_tready)
                begin
                    state_next    = IDLE_S;
                    m_tvalid_next = 1'b0;
                end
            end
            default:
            begin
                state_next    = IDLE_S;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE_S;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result is only offered while waiting in the response state
    a_valid_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (state_reg == RESP_S))
        else $error("result valid outside response state");

    // Execution always produces a result on the next cycle
    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EXEC_S) |=> m_tvalid_reg)
        else $error("execution did not raise result valid");

    // An accepted transaction goes straight to the stack lookup
    a_load_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == LOOKUP_S))
        else $error("accepted transaction not looked up");

endmodule

// ----- hdl/asa_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the aligned stack allocator: region registers, top pointer,
// entry stack memory, alignment and bounds arithmetic. Depends on asa_pkg.
module asa_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  asa_pkg::cmd_t                  cmd,
    input  asa_pkg::cfg_wr_t               cfg_wr,
    output asa_pkg::cfg_rd_t               cfg_rd,
    input  logic                           in_action,
    input  logic [asa_pkg::ADDR_W-1:0]     in_request_bytes,
    input  logic [asa_pkg::ALIGN_W-1:0]    in_alignment,
    input  logic [asa_pkg::ADDR_W-1:0]     in_block_address,
    output logic [asa_pkg::ADDR_W-1:0]     granted_address,
    output asa_pkg::status_t               status
);

    localparam int unsigned WIDE_W = asa_pkg::ADDR_W + 2;
    localparam int unsigned END_W  = asa_pkg::ADDR_W + 3;

    // Control state
    logic [asa_pkg::ADDR_W-1:0]  region_base_reg;
    logic [asa_pkg::ADDR_W-1:0]  region_bytes_reg;
    logic [asa_pkg::ADDR_W-1:0]  top_reg;
    logic [asa_pkg::COUNT_W-1:0] count_reg;

    // Captured request
    logic                         action_reg;
    logic [asa_pkg::ADDR_W-1:0]   size_reg;
    logic [asa_pkg::ALIGN_W-1:0]  align_reg;
    logic [asa_pkg::ADDR_W-1:0]   block_reg;

    // Lookup stage results
    asa_pkg::entry_t              rd_entry_reg;
    logic [WIDE_W-1:0]            aligned_reg;
    logic [WIDE_W-1:0]            limit_reg;
    logic                         bad_arg_reg;
    logic                         full_reg;

    // Result registers
    logic [asa_pkg::ADDR_W-1:0]   addr_reg;
    asa_pkg::status_t             status_reg;

    // Entry stack
    asa_pkg::entry_t              stack_mem [asa_pkg::STACK_DEPTH];

    logic [asa_pkg::COUNT_W-1:0]  slot_top;
    logic [WIDE_W-1:0]            align_ext;
    logic [WIDE_W-1:0]            aligned_sum;
    logic [END_W-1:0]             end_addr;
    logic                         past_end;
    logic [asa_pkg::ADJ_W-1:0]    adj;
    logic                         alloc_ok;
    logic                         free_ok;

    assign slot_top    = count_reg - 1'b1;
    assign align_ext   = {{(WIDE_W - asa_pkg::ALIGN_W){1'b0}}, align_reg};
    assign aligned_sum = {2'b00, top_reg} + WIDE_W'(asa_pkg::HEADER_BYTES)
                         + align_ext - 1'b1;

    // Bounds check against the region end and the 32-bit address space
    assign end_addr = {1'b0, aligned_reg} + {3'b000, size_reg};
    assign past_end = (end_addr > {1'b0, limit_reg})
                      || (end_addr > (END_W'(1) << asa_pkg::ADDR_W));
    assign adj      = aligned_reg[asa_pkg::ADJ_W-1:0] - top_reg[asa_pkg::ADJ_W-1:0];

    assign alloc_ok = (action_reg == asa_pkg::ACT_ALLOC) && !bad_arg_reg
                      && !full_reg && !past_end;
    assign free_ok  = (action_reg == asa_pkg::ACT_FREE) && (count_reg != '0)
                      && (rd_entry_reg.block == block_reg);

    // Capture request, prepare aligned address and stack read, push entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            size_reg   <= in_request_bytes;
            align_reg  <= in_alignment;
            block_reg  <= in_block_address;
        end
        if (cmd.lookup)
        begin
            rd_entry_reg <= stack_mem[slot_top[asa_pkg::SLOT_W-1:0]];
            aligned_reg  <= aligned_sum & ~(align_ext - 1'b1);
            limit_reg    <= {2'b00, region_base_reg} + {2'b00, region_bytes_reg};
            bad_arg_reg  <= (size_reg == '0) || (align_reg == '0)
                            || ((align_reg & (align_reg - 1'b1)) != '0);
            full_reg     <= (count_reg == asa_pkg::COUNT_W'(asa_pkg::STACK_DEPTH));
        end
        if (cmd.exec && alloc_ok)
        begin
            stack_mem[count_reg[asa_pkg::SLOT_W-1:0]] <=
                '{adj: adj, block: aligned_reg[asa_pkg::ADDR_W-1:0]};
        end
    end

    // Produce the result of the transaction
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (action_reg == asa_pkg::ACT_ALLOC)
            begin
                if (bad_arg_reg)
                begin
                    status_reg <= asa_pkg::ST_BAD_ARG;
                    addr_reg   <= '0;
                end
                else if (full_reg || past_end)
                begin
                    status_reg <= asa_pkg::ST_NO_MEM;
                    addr_reg   <= '0;
                end
                else
                begin
                    status_reg <= asa_pkg::ST_OK;
                    addr_reg   <= aligned_reg[asa_pkg::ADDR_W-1:0];
                end
            end
            else
            begin
                addr_reg <= '0;
                if (count_reg == '0)
                begin
                    status_reg <= asa_pkg::ST_EMPTY;
                end
                else if (!free_ok)
                begin
                    status_reg <= asa_pkg::ST_NOT_TOP;
                end
                else
                begin
                    status_reg <= asa_pkg::ST_OK;
                end
            end
        end
    end

    // Hold region registers; advance or rewind the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg  <= '0;
            region_bytes_reg <= '0;
            top_reg          <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_wr.base_we)
            begin
                region_base_reg <= cfg_wr.data;
                top_reg         <= cfg_wr.data;
                count_reg       <= '0;
            end
            else if (cmd.exec && alloc_ok)
            begin
                top_reg   <= end_addr[asa_pkg::ADDR_W-1:0];
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.exec && free_ok)
            begin
                top_reg   <= block_reg - {{(asa_pkg::ADDR_W - asa_pkg::ADJ_W){1'b0}},
                                          rd_entry_reg.adj};
                count_reg <= slot_top;
            end
            if (cfg_wr.bytes_we)
            begin
                region_bytes_reg <= cfg_wr.data;
            end
        end
    end

    assign cfg_rd.region_base  = region_base_reg;
    assign cfg_rd.region_bytes = region_bytes_reg;
    assign granted_address     = addr_reg;
    assign status              = status_reg;

    // The stack never holds more entries than it has slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= asa_pkg::COUNT_W'(asa_pkg::STACK_DEPTH))
        else $error("entry count beyond stack depth");

endmodule

// ----- hdl/aligned_stack_allocator.sv -----
`timescale 1ns / 1ps
// Aligned stack allocator, top level: stream ports, configuration port,
// controller and datapath. Depends on asa_pkg, asa_ctrl and asa_dp.
//
// Each request is accepted when the block is idle and yields one result
// after a lookup state (stack read, alignment step) and an execute state
// (bounds check and commit); the next request is accepted the cycle after
// the result is taken, so requests do not overlap. This order is set by
// the registered read of the 64-entry stack memory and the two-stage
// address arithmetic. Writing region_base empties the stack and moves the
// top to the new base; registers sit at byte addresses 0 and 4.
module aligned_stack_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // request_bytes[31:0], alignment[39:32], block_address[71:40]
    input  logic        s_tuser,   // action[0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // granted_address[31:0]
    output logic [2:0]  m_tuser    // status[2:0]
);

    asa_pkg::cmd_t    cmd;
    asa_pkg::cfg_wr_t cfg_wr;
    asa_pkg::cfg_rd_t cfg_rd;
    asa_pkg::status_t status;
    logic             wr_en;

    // Decode configuration writes
    assign pready          = 1'b1;
    assign wr_en           = psel && penable && pwrite && pready;
    assign cfg_wr.base_we  = wr_en && (paddr[2] == asa_pkg::REG_REGION_BASE);
    assign cfg_wr.bytes_we = wr_en && (paddr[2] == asa_pkg::REG_REGION_BYTES);
    assign cfg_wr.data     = pwdata;

    // Return the addressed register
    always_comb
    begin
        case (paddr[2])
            asa_pkg::REG_REGION_BASE:  prdata = cfg_rd.region_base;
            asa_pkg::REG_REGION_BYTES: prdata = cfg_rd.region_bytes;
            default:                   prdata = '0;
        endcase
    end

    asa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    asa_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_wr           (cfg_wr),
        .cfg_rd           (cfg_rd),
        .in_action        (s_tuser),
        .in_request_bytes (s_tdata[31:0]),
        .in_alignment     (s_tdata[39:32]),
        .in_block_address (s_tdata[71:40]),
        .granted_address  (m_tdata),
        .status           (status)
    );

    assign m_tuser = status;

endmodule
